[rtl/core/hvt_pkg.sv]
`default_nettype none
package hvt_pkg;

	// pi/2 in Q1.30, ln2 and 2*ln2/pi in Q0.28
	localparam logic [30:0] PIH_Q30 = 31'd1686629713;
	localparam logic [27:0] LN2_Q28 = 28'd186065279;
	localparam logic [27:0] SEC_Q28 = 28'd118452836;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	localparam int HORNER_STEPS  = 7;
	localparam int DIV_BITS      = 31;
	localparam int LOG_FRAC_BITS = 28;
	localparam int OUT_FRAC_BITS = 24;
	localparam int SCALE_SHIFT   = 56 - OUT_FRAC_BITS;

	// sideband through the angle, series and divider stages
	typedef struct packed {
		logic        vld;
		logic        flip;
		logic [4:0]  e;
		logic [30:0] my;
	} tag_t;

	// sideband through the log stages
	typedef struct packed {
		logic              vld;
		logic              flip;
		logic signed [6:0] ex;
	} lg_tag_t;

endpackage
`default_nettype wire

[rtl/core/hvt_horner_cell.sv]
`default_nettype none
module hvt_horner_cell
	import hvt_pkg::*;
#(
	parameter int DCOS = 2,
	parameter int DSIN = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire tag_t        tag_in,
	input  wire logic [29:0] z_in,
	input  wire logic [30:0] cos_in,
	input  wire logic [30:0] sin_in,
	output tag_t             tag_out,
	output logic [29:0]      z_out,
	output logic [30:0]      cos_out,
	output logic [30:0]      sin_out
);

	// exact floor division of a 31-bit value by a constant via reciprocal
	localparam int LC = $clog2(DCOS);
	localparam int LS = $clog2(DSIN);
	localparam logic [32:0] RC = 33'(((64'd1 << (31 + LC)) + 64'(DCOS) - 64'd1) / 64'(DCOS));
	localparam logic [32:0] RS = 33'(((64'd1 << (31 + LS)) + 64'(DSIN) - 64'd1) / 64'(DSIN));

	logic [60:0] pc_full, ps_full;
	logic [63:0] qc_full, qs_full;
	logic [30:0] pc_s1, ps_s1;
	logic [29:0] z_s1;
	tag_t        tag_s1;

	assign pc_full = {31'b0, z_in} * {30'b0, cos_in};
	assign ps_full = {31'b0, z_in} * {30'b0, sin_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1 <= pc_full[60:30];
			ps_s1 <= ps_full[60:30];
			z_s1  <= z_in;
		end
	end

	assign qc_full = {33'b0, pc_s1} * {31'b0, RC};
	assign qs_full = {33'b0, ps_s1} * {31'b0, RS};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out <= Q30_ONE - 31'(qc_full >> (31 + LC));
			sin_out <= Q30_ONE - 31'(qs_full >> (31 + LS));
			z_out   <= z_s1;
		end
	end

endmodule
`default_nettype wire

[rtl/core/hvt_div_cell.sv]
`default_nettype none
module hvt_div_cell
	import hvt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire tag_t        tag_in,
	input  wire logic        fill,
	input  wire logic [30:0] rem_in,
	input  wire logic [30:0] quo_in,
	input  wire logic [30:0] dvs_in,
	output tag_t             tag_out,
	output logic [30:0]      rem_out,
	output logic [30:0]      quo_out,
	output logic [30:0]      dvs_out
);

	logic [31:0] trial;
	logic [31:0] diff;
	logic        ge;

	// one restoring step: shift in a dividend bit, subtract if it fits
	assign trial = {rem_in, fill};
	assign ge    = trial >= {1'b0, dvs_in};
	assign diff  = trial - {1'b0, dvs_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? diff[30:0] : trial[30:0];
			quo_out <= {quo_in[29:0], ge};
			dvs_out <= dvs_in;
		end
	end

endmodule
`default_nettype wire

[rtl/core/hvt_log_cell.sv]
`default_nettype none
module hvt_log_cell
	import hvt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire lg_tag_t                  tag_in,
	input  wire logic [30:0]              m_in,
	input  wire logic [LOG_FRAC_BITS-1:0] frac_in,
	output lg_tag_t                       tag_out,
	output logic [30:0]                   m_out,
	output logic [LOG_FRAC_BITS-1:0]      frac_out
);

	logic [61:0] sq;
	logic        hi;

	// square the mantissa; a result of two or more yields a one bit
	assign sq = {31'b0, m_in} * {31'b0, m_in};
	assign hi = sq[61];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_out    <= hi ? sq[61:31] : sq[60:30];
			frac_out <= {frac_in[LOG_FRAC_BITS-2:0], hi};
		end
	end

endmodule
`default_nettype wire

[rtl/core/hyperbolic_variate_transform.sv]
`default_nettype none
// Hyperbolic variate transform. Each nonzero 32-bit uniform word u/2^32 yields
// one signed Q7.24 variate: ln(tan(pi/2*u)) when variant_select is 0 (hyperbolic
// cosine) and -(2/pi)*asinh(1/tan(pi*u)) when it is 1 (hyperbolic secant); a zero
// word is consumed and produces nothing. Results saturate at the ends of the range.
// The block takes one word per cycle while sample_stall is low. Each accepted
// word passes through a chain of cells for the angle, the seven cosine and sinc
// series steps (a product register, then a divide register each), a 31-cell
// restoring divider, the 28 squaring cells of the base-2 log, the final scale
// and an output register. A two-deep output stage lets the pipe keep taking
// words while a result waits to be taken; sample_stall rises only when both
// slots are full. Write variant_select only while no word is in flight.
module hyperbolic_variate_transform
	import hvt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        variant_we,
	input  wire logic        variant_wdata,
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  wire logic [31:0] uniform_fraction,
	output logic             variate_valid,
	input  wire logic        variate_stall,
	output logic [31:0]      variate_value
);

	logic variant_q;
	logic en;

	// output register plus skid slot
	logic        out_v_q, skid_v_q;
	logic [31:0] out_d_q, skid_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (variant_we) begin
			variant_q <= variant_wdata;
		end
	end

	// advance the whole pipe unless the skid slot holds a word
	assign en           = !skid_v_q;
	assign sample_stall = skid_v_q;

	// ---- fold and angle ----
	logic        flip;
	logic [31:0] y;
	logic [4:0]  e;
	logic [31:0] y_norm;
	logic [62:0] theta_full;
	logic [29:0] theta_s1;
	tag_t        tag_in, tag_s1;

	assign flip = uniform_fraction[31];
	assign y    = flip ? 32'(32'd0 - uniform_fraction) : uniform_fraction;

	always_comb begin
		e = '0;
		for (int i = 0; i < 32; i++) begin
			if (y[i]) begin
				e = 5'(i);
			end
		end
	end

	// mantissa with the leading one at bit 31; bits 31:1 give it in Q1.30
	assign y_norm     = y << (5'd31 - e);
	assign theta_full = {31'b0, y} * {32'b0, PIH_Q30};

	always_comb begin
		tag_in      = '0;
		tag_in.vld  = sample_valid && (uniform_fraction != 32'd0);
		tag_in.flip = flip;
		tag_in.e    = e;
		tag_in.my   = y_norm[31:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s1 <= theta_full[61:32];
		end
	end

	// ---- theta squared ----
	logic [59:0] z_full;
	logic [29:0] z_s2;
	tag_t        tag_s2;

	assign z_full = {30'b0, theta_s1} * {30'b0, theta_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= z_full[59:30];
		end
	end

	// ---- cosine and sinc series, highest term first ----
	tag_t        htag [HORNER_STEPS+1];
	logic [29:0] hz   [HORNER_STEPS+1];
	logic [30:0] hcos [HORNER_STEPS+1];
	logic [30:0] hsin [HORNER_STEPS+1];

	assign htag[0] = tag_s2;
	assign hz[0]   = z_s2;
	assign hcos[0] = Q30_ONE;
	assign hsin[0] = Q30_ONE;

	for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
		localparam int N = HORNER_STEPS - g;
		hvt_horner_cell #(
			.DCOS((2 * N) * (2 * N - 1)),
			.DSIN((2 * N + 1) * (2 * N))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tag_in (htag[g]),
			.z_in   (hz[g]),
			.cos_in (hcos[g]),
			.sin_in (hsin[g]),
			.tag_out(htag[g+1]),
			.z_out  (hz[g+1]),
			.cos_out(hcos[g+1]),
			.sin_out(hsin[g+1])
		);
	end

	// ---- sinc / cos, one quotient bit per cell ----
	tag_t        dtag [DIV_BITS+1];
	logic [30:0] drem [DIV_BITS+1];
	logic [30:0] dquo [DIV_BITS+1];
	logic [30:0] ddvs [DIV_BITS+1];

	// the quotient stays below two, so the top dividend bits start the remainder
	assign dtag[0] = htag[HORNER_STEPS];
	assign drem[0] = {1'b0, hsin[HORNER_STEPS][30:1]};
	assign dquo[0] = '0;
	assign ddvs[0] = hcos[HORNER_STEPS];

	for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
		hvt_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tag_in (dtag[g]),
			.fill   ((g == 0) ? hsin[HORNER_STEPS][0] : 1'b0),
			.rem_in (drem[g]),
			.quo_in (dquo[g]),
			.dvs_in (ddvs[g]),
			.tag_out(dtag[g+1]),
			.rem_out(drem[g+1]),
			.quo_out(dquo[g+1]),
			.dvs_out(ddvs[g+1])
		);
	end

	// ---- ratio times pi/2 ----
	logic [61:0] r_full;
	logic [31:0] r_s3;
	tag_t        tag_s3;

	assign r_full = {31'b0, dquo[DIV_BITS]} * {31'b0, PIH_Q30};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= dtag[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= r_full[61:30];
		end
	end

	// ---- mantissa product and exponent ----
	logic [62:0]       m_full;
	logic              m_hi;
	logic signed [6:0] ex;
	lg_tag_t           ltag_in;
	logic [30:0]       m_s4;
	lg_tag_t           ltag_s4;

	assign m_full = {32'b0, tag_s3.my} * {31'b0, r_s3};
	assign m_hi   = m_full[61];
	assign ex     = $signed({2'b00, tag_s3.e}) - 7'sd32 + $signed({6'b0, m_hi});

	always_comb begin
		ltag_in.vld  = tag_s3.vld;
		ltag_in.flip = tag_s3.flip;
		ltag_in.ex   = ex;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ltag_s4 <= '0;
		end else if (en) begin
			ltag_s4 <= ltag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4 <= m_hi ? m_full[61:31] : m_full[60:30];
		end
	end

	// ---- base-2 log fraction bits ----
	lg_tag_t                  ltag [LOG_FRAC_BITS+1];
	logic [30:0]              lm   [LOG_FRAC_BITS+1];
	logic [LOG_FRAC_BITS-1:0] lf   [LOG_FRAC_BITS+1];

	assign ltag[0] = ltag_s4;
	assign lm[0]   = m_s4;
	assign lf[0]   = '0;

	for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_log
		hvt_log_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tag_in  (ltag[g]),
			.m_in    (lm[g]),
			.frac_in (lf[g]),
			.tag_out (ltag[g+1]),
			.m_out   (lm[g+1]),
			.frac_out(lf[g+1])
		);
	end

	// ---- scale to the output format ----
	logic signed [34:0] l2;
	logic [33:0]        mag;
	logic               neg;
	logic [27:0]        scale_c;
	logic [61:0]        prod_full;
	logic [61:0]        prod_s5;
	logic               neg_s5;
	logic               vld_s5;

	assign l2      = {ltag[LOG_FRAC_BITS].ex, lf[LOG_FRAC_BITS]};
	assign mag     = l2[34] ? 34'(-l2) : l2[33:0];
	assign neg     = l2[34] ? !ltag[LOG_FRAC_BITS].flip
	                        : (ltag[LOG_FRAC_BITS].flip && (l2 != '0));
	assign scale_c = variant_q ? SEC_Q28 : LN2_Q28;
	assign prod_full = {28'b0, mag} * {34'b0, scale_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= ltag[LOG_FRAC_BITS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= prod_full;
			neg_s5  <= neg;
		end
	end

	// round half away from zero on the magnitude, clamp, then apply the sign
	logic [62:0] rnd;
	logic [31:0] om;
	logic [31:0] lim;
	logic [31:0] sat;
	logic [31:0] res;

	assign rnd = {1'b0, prod_s5} + (63'd1 << (SCALE_SHIFT - 1));
	assign om  = 32'(rnd >> SCALE_SHIFT);
	assign lim = neg_s5 ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign sat = (om > lim) ? lim : om;
	assign res = neg_s5 ? 32'(32'd0 - sat) : sat;

	// ---- output word and skid slot ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || !variate_stall) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= vld_s5;
				end
			end else if (en && vld_s5) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !variate_stall) begin
			out_d_q <= skid_v_q ? skid_d_q : res;
		end else if (en) begin
			skid_d_q <= res;
		end
	end

	assign variate_valid = out_v_q;
	assign variate_value = out_d_q;

endmodule
`default_nettype wire

[test/tb_hyperbolic_variate_transform.sv]
`default_nettype none
module tb_hyperbolic_variate_transform
	import hvt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY    = 79;
	localparam int IDLE_LIMIT = 20000;

	typedef enum logic {
		VAR_COSH = 1'b0,
		VAR_SECH = 1'b1
	} variant_e;

	logic        clk;
	logic        arst_n;
	logic        variant_we;
	logic        variant_wdata;
	logic        sample_valid;
	logic        sample_stall;
	logic [31:0] uniform_fraction;
	logic        variate_valid;
	logic        variate_stall;
	logic [31:0] variate_value;

	hyperbolic_variate_transform dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.variant_we      (variant_we),
		.variant_wdata   (variant_wdata),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.uniform_fraction(uniform_fraction),
		.variate_valid   (variate_valid),
		.variate_stall   (variate_stall),
		.variate_value   (variate_value)
	);

	// words waiting to be offered, and variates predicted but not yet seen
	logic [31:0] pending_words[$];
	logic [31:0] expected_variates[$];

	variant_e variant_mode;
	int       send_idle_pct;
	int       stall_pct;
	int       hold_off_cycles;
	bit       failed;
	bit       in_taken;
	int       idle_cycles;
	int       words_sent;
	int       variates_seen;
	int       mode_words[2];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cos (odd = 0) or sin(t)/t (odd = 1) in Q1.30 by Horner, highest term first
	function automatic logic [63:0] series_q30(logic [63:0] z, bit odd);
		logic [63:0] acc;
		logic [63:0] div;
		acc = 64'd1 << 30;
		for (int n = 7; n >= 1; n--) begin
			div = odd ? 64'((2*n + 1) * (2*n)) : 64'((2*n) * (2*n - 1));
			acc = (64'd1 << 30) - (((z * acc) >> 30) / div);
		end
		return acc;
	endfunction

	// predict the variate for one nonzero word under the given variant
	function automatic logic [31:0] predict_variate(logic [31:0] word, variant_e mode);
		logic [63:0] x, y, theta, z, cs, sn, q, r, my, m, frac, mag, prod, om, lim;
		logic        flip, neg;
		int          e, ex;
		longint      l2;
		x     = {32'd0, word};
		flip  = x >= 64'h8000_0000;
		y     = flip ? ((64'h1_0000_0000 - x) & 64'hFFFF_FFFF) : x;
		theta = (y * 64'(PIH_Q30)) >> 32;
		z     = (theta * theta) >> 30;
		cs    = series_q30(z, 1'b0);
		sn    = series_q30(z, 1'b1);
		q     = (sn << 30) / cs;
		r     = (64'(PIH_Q30) * q) >> 30;
		e = 63;
		while (e > 0 && y[e] == 1'b0)
			e--;
		my = (e >= 30) ? (y >> (e - 30)) : (y << (30 - e));
		m  = (my * r) >> 30;
		ex = e - 32;
		if (m >= (64'd1 << 31)) begin
			m  = m >> 1;
			ex = ex + 1;
		end
		frac = 0;
		for (int i = 0; i < LOG_FRAC_BITS; i++) begin
			m    = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 64'd1;
				m    = m >> 1;
			end
		end
		l2 = longint'(ex) * (64'sd1 <<< LOG_FRAC_BITS) + longint'(frac);
		if (l2 < 0) begin
			mag = 64'(-l2);
			neg = !flip;
		end else begin
			mag = 64'(l2);
			neg = flip && l2 != 0;
		end
		prod = mag * ((mode == VAR_SECH) ? 64'(SEC_Q28) : 64'(LN2_Q28));
		om   = (prod + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
		lim  = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
		if (om > lim)
			om = lim;
		return neg ? 32'(64'd0 - om) : om[31:0];
	endfunction

	// Driver: offer the head of the queue; advance once the word was taken at
	// the last rising edge. Valid never looks at stall, and a stalled word stays put.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_valid || in_taken) begin
				if (sample_valid)
					void'(pending_words.pop_front());
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_valid     <= 1'b1;
					uniform_fraction <= pending_words[0];
				end else begin
					sample_valid     <= 1'b0;
					uniform_fraction <= $urandom;
				end
			end
		end
	end

	// Receiver stall: random, or held high for a long stretch when asked.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			variate_stall   <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else
			variate_stall <= ($urandom_range(99) < stall_pct);
	end

	// Monitor: predict on each accepted word, check each accepted variate.
	always @(posedge clk) begin
		logic [31:0] want;
		bit          moved;
		if (arst_n) begin
			moved    = 1'b0;
			in_taken <= sample_valid && !sample_stall;
			if (sample_valid && !sample_stall) begin
				moved      = 1'b1;
				words_sent <= words_sent + 1;
				mode_words[variant_mode] <= mode_words[variant_mode] + 1;
				// a zero word is swallowed and yields no variate
				if (uniform_fraction != 32'd0)
					expected_variates.push_back(predict_variate(uniform_fraction, variant_mode));
			end
			if (variate_valid && !variate_stall) begin
				moved         = 1'b1;
				variates_seen <= variates_seen + 1;
				if (expected_variates.size() == 0) begin
					$error("variate_value: unexpected word %h", variate_value);
					failed <= 1'b1;
				end else begin
					want = expected_variates.pop_front();
					if (variate_value !== want) begin
						$error("variate_value: expected %h actual %h", want, variate_value);
						failed <= 1'b1;
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: stop if nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", idle_cycles);
			$display("tb_hyperbolic_variate_transform NOT OK");
			$finish;
		end
	end

	task automatic drain_pipe();
		while (pending_words.size() > 0 || sample_valid)
			@(posedge clk);
		while (expected_variates.size() > 0)
			@(posedge clk);
		// zero words make no variate but may still be in the pipe
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// write variant_select; only called with the pipe empty
	task automatic set_variant(variant_e mode);
		@(negedge clk);
		variant_we    <= 1'b1;
		variant_wdata <= mode;
		@(negedge clk);
		variant_we    <= 1'b0;
		variant_wdata <= 1'($urandom_range(1));
		variant_mode  = mode;
	endtask

	// well-formed random word: a third spread across the range, the rest near the ends, the fold point or a power of two
	function automatic logic [31:0] random_word();
		case ($urandom_range(5))
			0: return $urandom_range(255);
			1: return 32'hFFFF_FFFF - $urandom_range(255);
			2: return 32'h8000_0000 + $urandom_range(64) - 32;
			3: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(variant_e mode, int count, int idle_pct, int stl_pct);
		drain_pipe();
		set_variant(mode);
		send_idle_pct = idle_pct;
		stall_pct     = stl_pct;
		for (int i = 0; i < count; i++)
			pending_words.push_back(random_word());
	endtask

	initial begin
		logic [31:0] corner_words[$];
		arst_n           = 1'b0;
		variant_we       = 1'b0;
		variant_wdata    = 1'b0;
		sample_valid     = 1'b0;
		uniform_fraction = 32'd0;
		variate_stall    = 1'b0;
		variant_mode     = VAR_COSH;
		send_idle_pct    = 0;
		stall_pct        = 0;
		hold_off_cycles  = 0;
		failed           = 1'b0;
		in_taken         = 1'b0;
		idle_cycles      = 0;
		words_sent       = 0;
		variates_seen    = 0;
		mode_words       = '{0, 0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero, smallest, fold point, largest, saturation corners
		corner_words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0001, 32'h4000_0000, 32'hC000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'hAAAA_AAAA, 32'h5555_5555, 32'd0};
		foreach (corner_words[i])
			pending_words.push_back(corner_words[i]);
		drain_pipe();
		set_variant(VAR_SECH);
		foreach (corner_words[i])
			pending_words.push_back(corner_words[i]);

		run_phase(VAR_COSH, 100, 0, 0);
		run_phase(VAR_SECH, 100, 45, 0);
		run_phase(VAR_COSH, 100, 0, 45);
		run_phase(VAR_SECH, 100, 32, 32);

		// back-pressure: receiver holds off while the sender keeps offering
		drain_pipe();
		send_idle_pct   = 0;
		stall_pct       = 20;
		hold_off_cycles = 300;
		for (int i = 0; i < 100; i++)
			pending_words.push_back(random_word());

		drain_pipe();
		$display("covered %0d words (%0d cosh, %0d sech), %0d variates checked",
			words_sent, mode_words[0], mode_words[1], variates_seen);
		if (!failed && expected_variates.size() == 0)
			$display("tb_hyperbolic_variate_transform OK");
		else
			$display("tb_hyperbolic_variate_transform NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/hvt_pkg.sv
rtl/core/hvt_horner_cell.sv
rtl/core/hvt_div_cell.sv
rtl/core/hvt_log_cell.sv
rtl/core/hyperbolic_variate_transform.sv
test/tb_hyperbolic_variate_transform.sv
